// File: rtl/urs_pkg.sv
// Package with word types and command codes for the undo/redo snapshot ring.
package urs_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int SNAP_WIDTH_DEFAULT = 64;
   localparam int WORD_WIDTH         = 64;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_UNDO = 2'd1,
      CMD_REDO = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [WORD_WIDTH-1:0] snapshot_in;
   } req_word_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] snapshot_out;
      logic                  done_res;
      logic                  undo_possible;
      logic                  redo_possible;
   } rsp_word_type;

endpackage

// File: rtl/undo_redo_snapshot_ring.sv
// Top level of the undo/redo snapshot ring: history store, pointers and result register.
//
//   channel | ports                        | direction | word
//   --------+------------------------------+-----------+---------------
//   request | req_valid req_stall req_word | in        | req_word_type
//   result  | rsp_valid rsp_stall rsp_word | out       | rsp_word_type
//
// Takes one command each cycle unless stalled; its result appears in the next cycle.
// Pointers update and the store is written or read at the edge that takes the command;
// the read data register feeds snapshot_out after a successful undo or redo, else zero.
// Synchronous reset empties the history; store contents stay undefined until written.
// A stalled result holds, and req_stall rises while it waits.
module undo_redo_snapshot_ring #(
   parameter int DEPTH      = urs_pkg::DEPTH_DEFAULT,
   parameter int SNAP_WIDTH = urs_pkg::SNAP_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  urs_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output urs_pkg::rsp_word_type rsp_word
);

   import urs_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [PW-1:0] ring_idx(input logic [PW-1:0] base,
                                              input logic [PW-1:0] ofs);
      logic [PW:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= (PW+1)'(DEPTH)) begin
         sum = sum - (PW+1)'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   logic [SNAP_WIDTH-1:0] store_mem [DEPTH];

   logic [PW-1:0]         oldest_ff, oldest_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [PW-1:0]         offset_ff, offset_in;
   logic [SNAP_WIDTH-1:0] cur_val_ff, cur_val_in;
   logic                  mv_pend_ff, mv_pend_in;
   logic [SNAP_WIDTH-1:0] rd_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  done_ff, undo_ff, redo_ff, move_ff;

   logic                  accept;
   logic [SNAP_WIDTH-1:0] snap;
   logic [SNAP_WIDTH-1:0] cur_val;
   logic                  push_ok, move_ok, done_w;
   logic [PW-1:0]         addr;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign snap      = req_word.snapshot_in[SNAP_WIDTH-1:0];
   assign cur_val   = mv_pend_ff ? rd_ff : cur_val_ff;

   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      push_ok   = 1'b0;
      move_ok   = 1'b0;
      addr      = ring_idx(oldest_ff, offset_ff);
      unique case (req_word.cmd)
         CMD_PUSH: begin
            if (count_ff == '0) begin
               push_ok   = 1'b1;
               count_in  = CW'(1);
               offset_in = '0;
               addr      = oldest_ff;
            end else if (cur_val != snap) begin
               push_ok = 1'b1;
               if (offset_ff == PW'(DEPTH - 1)) begin
                  oldest_in = ring_idx(oldest_ff, PW'(1));
                  offset_in = PW'(DEPTH - 1);
               end else begin
                  offset_in = offset_ff + PW'(1);
               end
               count_in = CW'(offset_in) + CW'(1);
               addr     = ring_idx(oldest_in, offset_in);
            end
         end
         CMD_UNDO: begin
            if (offset_ff != '0) begin
               move_ok   = 1'b1;
               offset_in = offset_ff - PW'(1);
               addr      = ring_idx(oldest_ff, offset_in);
            end
         end
         CMD_REDO: begin
            if (CW'(offset_ff) + CW'(1) < count_ff) begin
               move_ok   = 1'b1;
               offset_in = offset_ff + PW'(1);
               addr      = ring_idx(oldest_ff, offset_in);
            end
         end
         default: begin
         end
      endcase
      done_w     = push_ok | move_ok;
      cur_val_in = (accept && push_ok) ? snap : cur_val;
      mv_pend_in = accept & move_ok;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (accept && push_ok) begin
         store_mem[addr] <= snap;
      end
      if (accept && move_ok) begin
         rd_ff <= store_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      cur_val_ff <= cur_val_in;
      if (accept) begin
         done_ff <= done_w;
         move_ff <= move_ok;
         undo_ff <= offset_in != '0;
         redo_ff <= CW'(offset_in) + CW'(1) < count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         mv_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            oldest_ff <= oldest_in;
            count_ff  <= count_in;
            offset_ff <= offset_in;
         end
         mv_pend_ff   <= mv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_word.snapshot_out  = move_ff ? WORD_WIDTH'(rd_ff) : '0;
   assign rsp_word.done_res      = done_ff;
   assign rsp_word.undo_possible = undo_ff;
   assign rsp_word.redo_possible = redo_ff;

endmodule
